[src/ilir_pkg.sv]
// Package for the indexed list block: command and status codes, the
// per-cycle control bundle broadcast to the storage cells, and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package ilir_pkg;

    // Default sizes for the top-level parameters
    localparam int DEFAULT_CAPACITY     = 64;
    localparam int DEFAULT_ELEMENT_BITS = 32;

    // Fixed port widths
    localparam int COMMAND_BITS  = 3;
    localparam int POSITION_BITS = 6;
    localparam int VALUE_BITS    = 32;
    localparam int STATUS_BITS   = 2;
    localparam int LENGTH_BITS   = 7;

    typedef enum logic [COMMAND_BITS-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_READ   = 3'd4
    } ilir_cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } ilir_status_t;

    // Actions that every cell sees in the same cycle; set only for
    // commands that succeed
    typedef struct packed {
        logic do_append;
        logic do_insert;
        logic do_remove;
    } ilir_ctrl_t;

endpackage

[src/ilir_cell.sv]
// One storage cell of the list: holds a single element and takes a new value
// from the input, its lower neighbour or its upper neighbour.
// Depends on ilir_pkg.
`timescale 1ns / 1ps

module ilir_cell
    import ilir_pkg::*;
#(
    parameter int INDEX        = 0,
    parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS,
    parameter int CMP_W        = 7
)
(
    input  logic                    clk,
    input  ilir_ctrl_t              ctrl,
    input  logic [CMP_W-1:0]        pos,
    input  logic [CMP_W-1:0]        count,
    input  logic [ELEMENT_BITS-1:0] new_value,
    input  logic [ELEMENT_BITS-1:0] from_lower,
    input  logic [ELEMENT_BITS-1:0] from_upper,
    output logic [ELEMENT_BITS-1:0] data,
    output logic [ELEMENT_BITS-1:0] read_data
);

    localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(INDEX);

    logic [ELEMENT_BITS-1:0] data_reg;
    logic [ELEMENT_BITS-1:0] data_next;
    logic                    at_pos;
    logic                    above_pos;

    assign at_pos    = (pos == MY_INDEX);
    assign above_pos = (MY_INDEX > pos);

    // Choose the source for this cell
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.do_append && (count == MY_INDEX))
        begin
            data_next = new_value;
        end
        else if (ctrl.do_insert)
        begin
            if (at_pos)
                data_next = new_value;
            else if (above_pos)
                data_next = from_lower;
        end
        else if (ctrl.do_remove && (at_pos || above_pos))
        begin
            data_next = from_upper;
        end
    end

    // Element payload, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign read_data = at_pos ? data_reg : '0;

endmodule

[src/indexed_list_insert_remove_top.sv]
// Top level of the indexed list: command decode, element count and result
// registers around a row of storage cells.
// Depends on ilir_pkg and ilir_cell.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY elements held in a row of cells, one element
// per cell. A command is taken on any clock edge where start is high; busy is
// always low, so one command can be issued every cycle. Insert and remove
// move all later cells by one place in the same edge, so every command's result
// (status, read_value, list_length) appears on the cycle after acceptance,
// marked by done for exactly one cycle, and must be captured then. After reset
// the list is empty; no clearing pass is needed.
module indexed_list_insert_remove_top
    import ilir_pkg::*;
#(
    parameter int CAPACITY     = DEFAULT_CAPACITY,
    parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [COMMAND_BITS-1:0]  command,
    input  logic [POSITION_BITS-1:0] position,
    input  logic [VALUE_BITS-1:0]    element_value,
    output logic                     done,
    output logic [STATUS_BITS-1:0]   status,
    output logic [VALUE_BITS-1:0]    read_value,
    output logic [LENGTH_BITS-1:0]   list_length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POSITION_BITS) ? CNT_W : POSITION_BITS;
    localparam logic [CMP_W-1:0] CAP_VAL = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    done_reg;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [STATUS_BITS-1:0]  status_next;
    logic [VALUE_BITS-1:0]   read_reg;
    logic [VALUE_BITS-1:0]   read_next;
    logic [LENGTH_BITS-1:0]  length_reg;
    logic [LENGTH_BITS-1:0]  length_next;

    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        count_ext;
    logic                    in_range;
    logic                    is_full;
    ilir_ctrl_t              ctrl;
    logic [ELEMENT_BITS-1:0] value_in;
    logic [ELEMENT_BITS-1:0] read_any;

    logic [ELEMENT_BITS-1:0] cell_data [CAPACITY];
    logic [ELEMENT_BITS-1:0] cell_read [CAPACITY];

    assign busy      = 1'b0;
    assign pos_ext   = CMP_W'(position);
    assign count_ext = CMP_W'(count_reg);
    assign in_range  = (pos_ext < count_ext);
    assign is_full   = (count_ext >= CAP_VAL);

    // Input value cut or widened to the element width
    always_comb
    begin
        for (int i = 0; i < ELEMENT_BITS; i++)
            value_in[i] = (i < VALUE_BITS) ? element_value[i] : 1'b0;
    end

    // Decode: cell actions, new count and status
    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = ST_OK;
        if (start)
        begin
            case (ilir_cmd_t'(command))
                CMD_APPEND:
                begin
                    if (is_full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.do_append = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                end
                CMD_INSERT:
                begin
                    if (!in_range)
                        status_next = ST_BOUNDS;
                    else if (is_full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.do_insert = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (!in_range)
                        status_next = ST_BOUNDS;
                    else
                    begin
                        ctrl.do_remove = 1'b1;
                        count_next     = count_reg - 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                CMD_READ:
                begin
                    if (!in_range)
                        status_next = ST_BOUNDS;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Row of cells; the ends feed back their own contents
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ELEMENT_BITS-1:0] lower;
        logic [ELEMENT_BITS-1:0] upper;

        if (g == 0)
        begin : g_first
            assign lower = cell_data[g];
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign upper = cell_data[g];
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[g+1];
        end

        ilir_cell #(
            .INDEX        (g),
            .ELEMENT_BITS (ELEMENT_BITS),
            .CMP_W        (CMP_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (pos_ext),
            .count      (count_ext),
            .new_value  (value_in),
            .from_lower (lower),
            .from_upper (upper),
            .data       (cell_data[g]),
            .read_data  (cell_read[g])
        );
    end

    // Only the addressed cell drives non-zero read data
    always_comb
    begin
        read_any = '0;
        for (int i = 0; i < CAPACITY; i++)
            read_any = read_any | cell_read[i];
    end

    // Result payload
    always_comb
    begin
        read_next = '0;
        if ((ilir_cmd_t'(command) == CMD_READ) && in_range)
        begin
            for (int i = 0; i < VALUE_BITS; i++)
                read_next[i] = (i < ELEMENT_BITS) ? read_any[i] : 1'b0;
        end
        for (int i = 0; i < LENGTH_BITS; i++)
            length_next[i] = (i < CNT_W) ? count_next[i] : 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    // Result registers, loaded on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg <= status_next;
            read_reg   <= read_next;
            length_reg <= length_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_reg;
    assign list_length = length_reg;

endmodule

[test/indexed_list_insert_remove_top_tb.sv]
// Testbench for indexed_list_insert_remove_top: directed and random command traffic
// with a cycle-free list predictor and a result checker on every done strobe.
// Depends on ilir_pkg and the indexed list RTL.
`timescale 1ns / 1ps

module indexed_list_insert_remove_top_tb;
    import ilir_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int ELEMENT_BITS = DEFAULT_ELEMENT_BITS;

    // Command codes the block does not decode; they must have no effect
    localparam logic [COMMAND_BITS-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [COMMAND_BITS-1:0] CMD_UNUSED_MID   = 3'd6;
    localparam logic [COMMAND_BITS-1:0] CMD_UNUSED_LAST  = 3'd7;

    localparam logic [VALUE_BITS-1:0] ELEMENT_MASK =
        {VALUE_BITS{1'b1}} >> (VALUE_BITS - ELEMENT_BITS);

    localparam int MAX_GAP        = 14;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = 200;
    localparam int PHASE_ITEMS    = 250;
    localparam int RANDOM_PHASES  = 8;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  read_value;
        logic [LENGTH_BITS-1:0] list_length;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [COMMAND_BITS-1:0]  command;
    logic [POSITION_BITS-1:0] position;
    logic [VALUE_BITS-1:0]    element_value;
    logic                     done;
    logic [STATUS_BITS-1:0]   status;
    logic [VALUE_BITS-1:0]    read_value;
    logic [LENGTH_BITS-1:0]   list_length;

    // Predictor copy of the list
    logic [VALUE_BITS-1:0] model_store [CAPACITY];
    int                    model_count;

    list_result_t expected_results [$];
    int           mismatch_count;
    bit           idle_on;

    indexed_list_insert_remove_top #(
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .position      (position),
        .element_value (element_value),
        .done          (done),
        .status        (status),
        .read_value    (read_value),
        .list_length   (list_length)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Expected result of one command, updating the predictor list
    task automatic predict_list_op(input logic [COMMAND_BITS-1:0] cmd,
                                   input logic [POSITION_BITS-1:0] pos,
                                   input logic [VALUE_BITS-1:0] val,
                                   output list_result_t res);
        int idx;
        int k;
        idx            = pos;
        res.status     = ST_OK;
        res.read_value = '0;
        case (cmd)
            CMD_APPEND:
                if (model_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    model_store[model_count] = val & ELEMENT_MASK;
                    model_count++;
                end
            CMD_INSERT:
                if (idx >= model_count)
                    res.status = ST_BOUNDS;
                else if (model_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (k = model_count; k > idx; k--)
                        model_store[k] = model_store[k - 1];
                    model_store[idx] = val & ELEMENT_MASK;
                    model_count++;
                end
            CMD_REMOVE:
                if (idx >= model_count)
                    res.status = ST_BOUNDS;
                else
                begin
                    for (k = idx; k + 1 < model_count; k++)
                        model_store[k] = model_store[k + 1];
                    model_count--;
                end
            CMD_CLEAR:
                model_count = 0;
            CMD_READ:
                if (idx >= model_count)
                    res.status = ST_BOUNDS;
                else
                    res.read_value = model_store[idx];
            default: ;
        endcase
        res.list_length = LENGTH_BITS'(model_count);
    endtask

    task automatic report_mismatch(input string field, input logic [VALUE_BITS-1:0] exp_val,
                                   input logic [VALUE_BITS-1:0] act_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field,
                     exp_val, act_val);
    endtask

    // Check each result transaction against the oldest expectation
    always @(negedge clk)
    begin : result_checker
        list_result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result (status)", '0, VALUE_BITS'(status));
            else
            begin
                exp_res = expected_results.pop_front();
                if (status !== exp_res.status)
                    report_mismatch("status", VALUE_BITS'(exp_res.status),
                                    VALUE_BITS'(status));
                if (read_value !== exp_res.read_value)
                    report_mismatch("read_value", exp_res.read_value, read_value);
                if (list_length !== exp_res.list_length)
                    report_mismatch("list_length", VALUE_BITS'(exp_res.list_length),
                                    VALUE_BITS'(list_length));
            end
        end
    end

    // Send one command transaction; entered and left just after a rising edge
    task automatic send_list_cmd(input logic [COMMAND_BITS-1:0] cmd,
                                 input logic [POSITION_BITS-1:0] pos,
                                 input logic [VALUE_BITS-1:0] val);
        int           gap;
        list_result_t res;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        command       <= cmd;
        position      <= pos;
        element_value <= val;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predict_list_op(cmd, pos, val, res);
        expected_results.push_back(res);
    endtask

    // Hold off until every outstanding result has come back or the drain limit is reached
    task automatic wait_results_drained();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Position near the live range: valid indexes, the end, or anything
    function automatic logic [POSITION_BITS-1:0] pick_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (model_count > 0 && roll < 75)
            return POSITION_BITS'($urandom_range(0, model_count - 1));
        else if (model_count < CAPACITY && roll < 88)
            return POSITION_BITS'(model_count);
        else
            return POSITION_BITS'($urandom);
    endfunction

    function automatic logic [COMMAND_BITS-1:0] pick_command(input bit grow);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (grow ? 35 : 15))
            return CMD_APPEND;
        else if (roll < (grow ? 65 : 30))
            return CMD_INSERT;
        else if (roll < (grow ? 75 : 65))
            return CMD_REMOVE;
        else if (roll < 95)
            return CMD_READ;
        else if (roll < 97)
            return CMD_CLEAR;
        else
            return COMMAND_BITS'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    endfunction

    // Errors on an empty list, including insert at index equal to the length
    task automatic test_empty_list_errors();
        send_list_cmd(CMD_READ,   '0, '0);
        send_list_cmd(CMD_REMOVE, '0, '0);
        send_list_cmd(CMD_INSERT, '0, 32'hDEAD_BEEF);
        send_list_cmd(CMD_READ,   {POSITION_BITS{1'b1}}, '0);
        send_list_cmd(CMD_CLEAR,  '0, '0);
    endtask

    // Each command on a short list, value extremes, unknown codes
    task automatic test_basic_edit_ops();
        send_list_cmd(CMD_APPEND, '0, '0);
        send_list_cmd(CMD_APPEND, {POSITION_BITS{1'b1}}, {VALUE_BITS{1'b1}});
        send_list_cmd(CMD_APPEND, '0, 32'hA5A5_5A5A);
        send_list_cmd(CMD_INSERT, '0, 32'h1234_5678);
        send_list_cmd(CMD_INSERT, 6'd2, 32'h8000_0001);
        send_list_cmd(CMD_INSERT, 6'd5, 32'h0BAD_F00D);
        send_list_cmd(CMD_READ,   '0, '0);
        send_list_cmd(CMD_READ,   6'd2, '0);
        send_list_cmd(CMD_READ,   6'd4, '0);
        send_list_cmd(CMD_READ,   6'd5, '0);
        send_list_cmd(CMD_REMOVE, 6'd4, '0);
        send_list_cmd(CMD_REMOVE, '0, '0);
        send_list_cmd(CMD_READ,   '0, '0);
        send_list_cmd(CMD_UNUSED_FIRST, 6'd1, {VALUE_BITS{1'b1}});
        send_list_cmd(CMD_UNUSED_MID, 6'd0, 32'h5555_5555);
        send_list_cmd(CMD_UNUSED_LAST, {POSITION_BITS{1'b1}}, '0);
        send_list_cmd(CMD_CLEAR,  '0, '0);
        send_list_cmd(CMD_READ,   '0, '0);
        send_list_cmd(CMD_APPEND, '0, 32'hCAFE_0000);
        send_list_cmd(CMD_READ,   '0, '0);
    endtask

    // Fill to capacity, then the full cases and the top index
    task automatic test_fill_to_capacity();
        int n;
        send_list_cmd(CMD_CLEAR, '0, '0);
        for (n = 0; n < CAPACITY; n++)
            send_list_cmd(CMD_APPEND, POSITION_BITS'($urandom), $urandom);
        send_list_cmd(CMD_APPEND, '0, $urandom);
        send_list_cmd(CMD_INSERT, '0, $urandom);
        send_list_cmd(CMD_INSERT, {POSITION_BITS{1'b1}}, $urandom);
        send_list_cmd(CMD_READ,   {POSITION_BITS{1'b1}}, '0);
        send_list_cmd(CMD_REMOVE, {POSITION_BITS{1'b1}}, '0);
        send_list_cmd(CMD_READ,   {POSITION_BITS{1'b1}}, '0);
        send_list_cmd(CMD_INSERT, {POSITION_BITS{1'b1}} - 1'b1, 32'hFFFF_0000);
        send_list_cmd(CMD_READ,   {POSITION_BITS{1'b1}}, '0);
        send_list_cmd(CMD_REMOVE, '0, '0);
        send_list_cmd(CMD_READ,   '0, '0);
    endtask

    // Random traffic; growth and shrink phases swing the length end to end
    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = (phase % 3) != 1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_list_cmd(pick_command(phase % 2 == 0), pick_position(), $urandom);
            if (phase % 2 == 1)
                wait_results_drained();
        end
    endtask

    // Stimulus and final verdict
    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        command        <= CMD_APPEND;
        position       <= '0;
        element_value  <= '0;
        model_count    = 0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list_errors();
        test_basic_edit_ops();
        wait_results_drained();
        test_fill_to_capacity();
        test_random_traffic();

        wait_results_drained();
        repeat (5) @(posedge clk);
        if (expected_results.size() != 0)
            mismatch_count += expected_results.size();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
src/ilir_pkg.sv
src/ilir_cell.sv
src/indexed_list_insert_remove_top.sv
test/indexed_list_insert_remove_top_tb.sv
